[hdl/tlptw_pkg.sv]
// Package for the two-level page table walker.
// Holds memory sizing, command, descriptor and status codes, and the
// controller/datapath interface structs. No dependencies.
package tlptw_pkg;

    // Descriptor memory sizing.
    localparam int MEM_WORDS = 16384;
    localparam int MEM_AW = $clog2(MEM_WORDS);
    localparam logic [MEM_AW-1:0] MEM_LAST = MEM_AW'(MEM_WORDS - 1);
    localparam logic [31:0] MEM_LIMIT = 32'(MEM_WORDS);

    // Number of level-one entries that a section map may touch.
    localparam logic [12:0] L1_ENTRIES = 13'd4096;

    // Configuration register indexes.
    localparam logic CFG_TABLE_BASE = 1'b0;
    localparam logic CFG_PROCESS_ID = 1'b1;

    // Input commands.
    typedef enum logic [1:0] {
        CMD_WRITE     = 2'd0,
        CMD_TRANSLATE = 2'd1,
        CMD_MAP       = 2'd2
    } command_t;

    // Descriptor type codes in bits 1:0 of a table entry.
    localparam logic [1:0] DESC_FAULT   = 2'd0;
    localparam logic [1:0] L1_COARSE    = 2'd1;
    localparam logic [1:0] L1_SECTION   = 2'd2;
    localparam logic [1:0] L2_SMALL     = 2'd2;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FAULT   = 3'd1,
        ST_UNSUP   = 3'd2,
        ST_WRITTEN = 3'd3,
        ST_CLIPPED = 3'd4
    } status_t;

    // Which result the datapath captures.
    typedef enum logic [2:0] {
        RES_NONE,
        RES_SECTION,
        RES_PAGE,
        RES_FAULT,
        RES_UNSUP,
        RES_WRITTEN,
        RES_MAP
    } res_sel_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_L1_DECODE,
        S_L2_DECODE,
        S_MAP,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_in;
        logic     clr_we;
        logic     wr_we;
        logic     map_we;
        logic     rd_l1;
        logic     rd_l2;
        res_sel_t res_sel;
        logic     out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       clr_last;
        logic [1:0] cmd;
        logic [1:0] desc_type;
        logic       map_done;
    } dp_stat_t;

endpackage

[hdl/two_level_page_table_walker.sv]
// Top level of the two-level page table walker.
// Joins the controller and the datapath. Depends on tlptw_pkg,
// tlptw_ctrl and tlptw_dpath.
//
//  Channel  Handshake              Payload
//  -------  ---------------------  ------------------------------------
//  in       in_valid / in_ready    command, address, data, flags, count
//  out      out_valid / out_ready  phys_addr, status
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// After reset a clearing pass zeroes the descriptor memory, one word a
// cycle over all MEM_WORDS (16384) words; no item is taken meanwhile, while
// configuration writes are always taken. Each item then occupies the walker
// until its result is loaded into the output register: a write or an
// unsupported command goes through dispatch only, a section translation
// through one level-one read, a page translation through two dependent reads
// on the single memory read port, and a section map through one write a
// cycle on the memory write port for each entry written. A result that waits
// in the output register holds the next item in its last step.
module two_level_page_table_walker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [31:0] address,
    input  logic [31:0] data,
    input  logic [19:0] flags,
    input  logic [12:0] count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] phys_addr,
    output logic [2:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [17:0] cfg_data
);
    import tlptw_pkg::*;

    ctrl_cmd_t ctl;
    dp_stat_t  stat;
    logic      cfg_we;

    // Configuration writes are taken in every cycle.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // Controller.
    tlptw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    // Datapath.
    tlptw_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .command   (command),
        .address   (address),
        .data      (data),
        .flags     (flags),
        .count     (count),
        .phys_addr (phys_addr),
        .status    (status)
    );

endmodule

[hdl/tlptw_ctrl.sv]
// Controller state machine of the page table walker.
// Sequences memory clearing, word writes, table walks and section maps.
// Depends on tlptw_pkg.
module tlptw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  tlptw_pkg::dp_stat_t   stat,
    output tlptw_pkg::ctrl_cmd_t  ctl
);
    import tlptw_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // State and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                unique case (stat.cmd)
                    CMD_TRANSLATE: state_next = S_L1_DECODE;
                    CMD_MAP:       state_next = S_MAP;
                    default:       state_next = S_FINISH;
                endcase
            end
            S_L1_DECODE:
            begin
                if (stat.desc_type == L1_COARSE)
                    state_next = S_L2_DECODE;
                else
                    state_next = S_FINISH;
            end
            S_L2_DECODE:
            begin
                state_next = S_FINISH;
            end
            S_MAP:
            begin
                if (stat.map_done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Datapath commands.
    always_comb
    begin
        ctl         = '0;
        ctl.res_sel = RES_NONE;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_we = 1'b1;
            end
            S_IDLE:
            begin
                ctl.load_in = in_valid;
            end
            S_DISPATCH:
            begin
                unique case (stat.cmd)
                    CMD_WRITE:
                    begin
                        ctl.wr_we   = 1'b1;
                        ctl.res_sel = RES_WRITTEN;
                    end
                    CMD_TRANSLATE:
                    begin
                        ctl.rd_l1 = 1'b1;
                    end
                    CMD_MAP:
                    begin
                        ctl.res_sel = RES_NONE;
                    end
                    default:
                    begin
                        ctl.res_sel = RES_UNSUP;
                    end
                endcase
            end
            S_L1_DECODE:
            begin
                unique case (stat.desc_type)
                    DESC_FAULT: ctl.res_sel = RES_FAULT;
                    L1_COARSE:  ctl.rd_l2   = 1'b1;
                    L1_SECTION: ctl.res_sel = RES_SECTION;
                    default:    ctl.res_sel = RES_UNSUP;
                endcase
            end
            S_L2_DECODE:
            begin
                unique case (stat.desc_type)
                    DESC_FAULT: ctl.res_sel = RES_FAULT;
                    L2_SMALL:   ctl.res_sel = RES_PAGE;
                    default:    ctl.res_sel = RES_UNSUP;
                endcase
            end
            S_MAP:
            begin
                if (stat.map_done)
                    ctl.res_sel = RES_MAP;
                else
                    ctl.map_we = 1'b1;
            end
            S_FINISH:
            begin
                ctl.out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                ctl.res_sel = RES_NONE;
            end
        endcase
    end

    // Output valid: set on a load, cleared on a transfer.
    always_comb
    begin
        if (ctl.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[hdl/tlptw_dpath.sv]
// Datapath of the page table walker: configuration registers, item
// registers, descriptor memory, map counter and result registers.
// Depends on tlptw_pkg.
module tlptw_dpath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tlptw_pkg::ctrl_cmd_t  ctl,
    output tlptw_pkg::dp_stat_t   stat,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [17:0]           cfg_data,
    input  logic [1:0]            command,
    input  logic [31:0]           address,
    input  logic [31:0]           data,
    input  logic [19:0]           flags,
    input  logic [12:0]           count,
    output logic [31:0]           phys_addr,
    output logic [2:0]            status
);
    import tlptw_pkg::*;

    // Configuration registers.
    logic [17:0] table_base_reg;
    logic [6:0]  process_id_reg;

    // Item registers.
    logic [1:0]  cmd_reg;
    logic [31:0] va_reg;
    logic [31:0] data_reg;
    logic [19:0] flags_reg;
    logic [12:0] nwr_reg;
    logic        clipped_reg;
    logic [12:0] i_reg;

    // Clearing pass counter.
    logic [MEM_AW-1:0] clr_reg;

    // Descriptor memory and its registered read port.
    logic [31:0] mem [MEM_WORDS];
    logic [31:0] rd_data_reg;
    logic        rd_ok_reg;

    // Result and output registers.
    logic [31:0] res_phys_reg;
    logic [2:0]  res_status_reg;
    logic [31:0] phys_addr_reg;
    logic [2:0]  status_reg;

    logic        reloc;
    logic [31:0] va_in;
    logic [12:0] map_limit;
    logic        map_clip;
    logic [31:0] desc;
    logic [29:0] l1_addr;
    logic [29:0] l2_addr;
    logic [29:0] rd_addr;
    logic        rd_in_range;
    logic [11:0] map_idx;
    logic [29:0] map_addr;
    logic [31:0] map_entry;
    logic [31:0] wr_addr;
    logic [31:0] wr_data;
    logic        wr_en;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_base_reg <= '0;
            process_id_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_TABLE_BASE)
                table_base_reg <= cfg_data;
            else
                process_id_reg <= cfg_data[6:0];
        end
    end

    // Low addresses of a translation are relocated by the process id.
    assign reloc = (command == CMD_TRANSLATE) && (address[31:25] == 7'd0);
    assign va_in = reloc ? {process_id_reg, address[24:0]} : address;

    // Section maps stop at the last level-one entry.
    assign map_limit = L1_ENTRIES - {1'b0, address[31:20]};
    assign map_clip  = count > map_limit;

    // Capture the accepted item.
    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            cmd_reg     <= command;
            va_reg      <= va_in;
            data_reg    <= data;
            flags_reg   <= flags;
            nwr_reg     <= map_clip ? map_limit : count;
            clipped_reg <= map_clip;
        end
    end

    // Section map index and clearing pass counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg   <= '0;
            clr_reg <= '0;
        end
        else
        begin
            if (ctl.load_in)
                i_reg <= '0;
            else if (ctl.map_we)
                i_reg <= i_reg + 13'd1;
            if (ctl.clr_we)
                clr_reg <= clr_reg + MEM_AW'(1);
        end
    end

    // Table addresses; the low address bits of each base are zero.
    assign desc      = rd_ok_reg ? rd_data_reg : '0;
    assign l1_addr   = {table_base_reg, va_reg[31:20]};
    assign l2_addr   = {desc[31:10], va_reg[19:12]};
    assign rd_addr   = ctl.rd_l2 ? l2_addr : l1_addr;
    assign rd_in_range = {2'b00, rd_addr} < MEM_LIMIT;
    assign map_idx   = va_reg[31:20] + i_reg[11:0];
    assign map_addr  = {table_base_reg, map_idx};
    assign map_entry = {data_reg[31:20] + i_reg[11:0], flags_reg};

    // Write port select: clearing pass, word write, or section entry.
    always_comb
    begin
        wr_addr = {2'b00, map_addr};
        wr_data = map_entry;
        wr_en   = 1'b0;
        priority if (ctl.clr_we)
        begin
            wr_addr = 32'(clr_reg);
            wr_data = '0;
            wr_en   = 1'b1;
        end
        else if (ctl.wr_we)
        begin
            wr_addr = va_reg;
            wr_data = data_reg;
            wr_en   = va_reg < MEM_LIMIT;
        end
        else if (ctl.map_we)
        begin
            wr_en = {2'b00, map_addr} < MEM_LIMIT;
        end
    end

    // Memory write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr[MEM_AW-1:0]] <= wr_data;
    end

    // Memory read port; words outside the memory read as zero.
    always_ff @(posedge clk)
    begin
        if (ctl.rd_l1 || ctl.rd_l2)
        begin
            rd_data_reg <= mem[rd_addr[MEM_AW-1:0]];
            rd_ok_reg   <= rd_in_range;
        end
    end

    // Result capture.
    always_ff @(posedge clk)
    begin
        unique case (ctl.res_sel)
            RES_SECTION:
            begin
                res_phys_reg   <= {desc[31:20], va_reg[19:0]};
                res_status_reg <= ST_OK;
            end
            RES_PAGE:
            begin
                res_phys_reg   <= {desc[31:12], va_reg[11:0]};
                res_status_reg <= ST_OK;
            end
            RES_FAULT:
            begin
                res_phys_reg   <= '0;
                res_status_reg <= ST_FAULT;
            end
            RES_UNSUP:
            begin
                res_phys_reg   <= '0;
                res_status_reg <= ST_UNSUP;
            end
            RES_WRITTEN:
            begin
                res_phys_reg   <= '0;
                res_status_reg <= ST_WRITTEN;
            end
            RES_MAP:
            begin
                res_phys_reg   <= '0;
                res_status_reg <= clipped_reg ? ST_CLIPPED : ST_WRITTEN;
            end
            default:
            begin
                res_phys_reg   <= res_phys_reg;
                res_status_reg <= res_status_reg;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            phys_addr_reg <= res_phys_reg;
            status_reg    <= res_status_reg;
        end
    end

    assign stat.clr_last  = (clr_reg == MEM_LAST);
    assign stat.cmd       = cmd_reg;
    assign stat.desc_type = desc[1:0];
    assign stat.map_done  = (i_reg == nwr_reg);

    assign phys_addr = phys_addr_reg;
    assign status    = status_reg;

endmodule
